>>> rtl/agbs_pkg.sv
// Shared constants, types and helper functions for the alpha gradient bevel shader.
package agbs_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int RING_LEN   = 2 * MAX_WIDTH + 4;
  localparam int SLOT_W     = $clog2(RING_LEN);
  localparam int ADDR_SW    = SLOT_W + 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LIN_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DIM_W      = 12;
  localparam int THICK_W    = 6;
  localparam int TRIG_W     = 16;
  localparam int GAIN_W     = 12;
  localparam int RGB_W      = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_AW     = 3;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;

  localparam int GRAD_W     = 11;
  localparam int DOT_W      = 28;
  localparam int ABS_W      = 27;
  localparam int GM_W       = 18;
  localparam int DG_W       = 45;
  localparam int N_W        = 53;
  localparam int FRAC_SH    = 22;
  localparam int NH_W       = N_W - FRAC_SH;
  localparam int DEN_W      = 14;
  localparam int Q_W        = 8;
  localparam int NBR_N      = 9;
  localparam int NBR_IW     = 4;
  localparam int CNT_W      = 4;

  localparam logic [CH_W-1:0] ALPHA_MIN     = 8'd3;
  localparam logic [CH_W-1:0] SHADOW_WEIGHT = 8'd40;
  localparam logic [CH_W-1:0] CH_MAX        = 8'd255;

  typedef enum logic [CFG_AW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_THICK  = 3'd2,
    REG_COS    = 3'd3,
    REG_SIN    = 3'd4,
    REG_GAIN   = 3'd5,
    REG_RGB    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              in_ready;
    logic              rd_en;
    logic [NBR_IW-1:0] rd_idx;
    logic              acc_en;
    logic [NBR_IW-1:0] acc_idx;
    logic              mul1;
    logic              mul2;
    logic              mul3;
    logic              mul4;
    logic              div_init;
    logic              div_step;
    logic [2:0]        div_bit;
    logic              load;
  } agbs_cmd_t;

  typedef struct packed {
    logic accept;
    logic emit;
    logic out_free;
  } agbs_sts_t;

  // Neighbor order: center, then top row, middle row sides, bottom row.
  function automatic logic signed [1:0] nbr_dx(input logic [NBR_IW-1:0] idx);
    logic signed [1:0] v;
    unique case (idx)
      4'd1, 4'd4, 4'd6: v = -2'sd1;
      4'd3, 4'd5, 4'd8: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] nbr_dy(input logic [NBR_IW-1:0] idx);
    logic signed [1:0] v;
    unique case (idx)
      4'd1, 4'd2, 4'd3: v = -2'sd1;
      4'd6, 4'd7, 4'd8: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/agbs_pix_in_if.sv
// Input pixel channel: valid/ready handshake with op and RGBA payload.
interface agbs_pix_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, output op, output in_red, output in_green,
                  output in_blue, output in_alpha, input ready);
  modport sink   (input valid, input op, input in_red, input in_green,
                  input in_blue, input in_alpha, output ready);
endinterface

>>> rtl/agbs_pix_out_if.sv
// Result pixel channel: valid/ready handshake with shaded RGBA and frame end.
interface agbs_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, input frame_end, output ready);
endinterface

>>> rtl/agbs_ram.sv
// Generic simple dual-port RAM with registered read.
module agbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/agbs_ctrl.sv
// Controller state machine sequencing reads, multiplies and division per pixel.
module agbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  agbs_pkg::agbs_sts_t sts,
  output agbs_pkg::agbs_cmd_t cmd
);
  import agbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_DIVI, S_DIV, S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (sts.accept && sts.emit) begin
            state_r <= S_READ;
            cnt_r   <= '0;
          end
        end
        S_READ: begin
          if (cnt_r == CNT_W'(NBR_N)) begin
            state_r <= S_MUL1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: state_r <= S_MUL4;
        S_MUL4: state_r <= S_DIVI;
        S_DIVI: begin
          state_r <= S_DIV;
          cnt_r   <= CNT_W'(Q_W - 1);
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_idx   = cnt_r;
    cmd.acc_idx  = cnt_r - 1'b1;
    cmd.div_bit  = cnt_r[2:0];
    cmd.in_ready = (state_r == S_IDLE);
    cmd.rd_en    = (state_r == S_READ) && (cnt_r < CNT_W'(NBR_N));
    cmd.acc_en   = (state_r == S_READ) && (cnt_r != '0);
    cmd.mul1     = (state_r == S_MUL1);
    cmd.mul2     = (state_r == S_MUL2);
    cmd.mul3     = (state_r == S_MUL3);
    cmd.mul4     = (state_r == S_MUL4);
    cmd.div_init = (state_r == S_DIVI);
    cmd.div_step = (state_r == S_DIV);
    cmd.load     = (state_r == S_OUT) && sts.out_free;
  end
endmodule

>>> rtl/agbs_dp.sv
// Datapath: configuration, stream counters, line store, gradient and shading arithmetic.
module agbs_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [agbs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [agbs_pkg::CFG_W-1:0]  cfg_wdata,
  agbs_pix_in_if.sink                in_chan,
  agbs_pix_out_if.source             out_chan,
  input  agbs_pkg::agbs_cmd_t        cmd,
  output agbs_pkg::agbs_sts_t        sts
);
  import agbs_pkg::*;

  // configuration
  logic [DIM_W-1:0]         width_r, height_r;
  logic [THICK_W-1:0]       thick_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [RGB_W-1:0]         rgb_r;

  // stream position
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [LIN_W-1:0]  in_lin_r, out_lin_r, total_r;
  logic [SLOT_W-1:0] in_slot_r, out_slot_r;
  logic              frame_rcv_r;

  // arithmetic
  logic [PIX_W-1:0]         pix_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [DOT_W-1:0]  p1_r, p2_r;
  logic [GM_W-1:0]          gm_r;
  logic [DEN_W-1:0]         den_r;
  logic                     pos_r;
  logic [ABS_W-1:0]         abs_r;
  logic [DG_W-1:0]          dg_r;
  logic [NH_W-1:0]          nh_r  [3];
  logic                     nz_r  [3];
  logic [NH_W-1:0]          rem_r [3];
  logic [Q_W-1:0]           q_r   [3];
  logic                     big_r [3];

  // output register
  logic            ov_r, fe_r;
  logic [CH_W-1:0] or_r, og_r, ob_r, oa_r;

  logic [DIM_W-1:0] w_eff, h_eff;
  always_comb begin
    if (width_r == '0)                      w_eff = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_WIDTH))   w_eff = DIM_W'(MAX_WIDTH);
    else                                    w_eff = width_r;
    if (height_r == '0)                     h_eff = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else                                    h_eff = height_r;
  end

  logic accept;
  assign in_chan.ready = cmd.in_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // input advance
  logic [DIM_W-1:0] in_col_inc, in_row_inc;
  logic             col_wrap, frame_wrap;
  logic [LIN_W-1:0] delivered, out_lin_eff, gap;
  logic [SLOT_W-1:0] in_slot_inc, out_slot_inc;
  always_comb begin
    in_col_inc  = DIM_W'(in_col_r) + 1'b1;
    in_row_inc  = DIM_W'(in_row_r) + 1'b1;
    col_wrap    = (in_col_inc >= w_eff);
    frame_wrap  = col_wrap && (in_row_inc >= h_eff);
    delivered   = frame_wrap ? total_r : in_lin_r + 1'b1;
    out_lin_eff = frame_rcv_r ? '0 : out_lin_r;
    gap         = delivered - out_lin_eff;
    in_slot_inc = (in_slot_r == SLOT_W'(RING_LEN - 1)) ? '0 : in_slot_r + 1'b1;
    out_slot_inc = (out_slot_r == SLOT_W'(RING_LEN - 1)) ? '0 : out_slot_r + 1'b1;
  end

  logic emit_now;
  always_comb begin
    if (in_chan.op) begin
      emit_now = frame_rcv_r && (out_lin_r < total_r);
    end else begin
      emit_now = (gap > LIN_W'(w_eff) + 1'b1);
    end
  end

  logic out_free;
  assign out_free     = !ov_r || out_chan.ready;
  assign sts.accept   = accept;
  assign sts.emit     = emit_now;
  assign sts.out_free = out_free;

  // neighbor address with clamped borders
  logic x_first, x_last, y_first, y_last;
  logic signed [1:0] dx, dy, dxc, dyc;
  logic signed [ADDR_SW-1:0] off, asum;
  logic [SLOT_W-1:0] raddr;
  always_comb begin
    x_first = (out_col_r == '0);
    x_last  = (DIM_W'(out_col_r) == w_eff - 1'b1);
    y_first = (out_row_r == '0);
    y_last  = (DIM_W'(out_row_r) == h_eff - 1'b1);
    dx  = nbr_dx(cmd.rd_idx);
    dy  = nbr_dy(cmd.rd_idx);
    dxc = ((dx < 0 && x_first) || (dx > 0 && x_last)) ? 2'sd0 : dx;
    dyc = ((dy < 0 && y_first) || (dy > 0 && y_last)) ? 2'sd0 : dy;
    if (dyc > 0)      off = $signed(ADDR_SW'(w_eff));
    else if (dyc < 0) off = -$signed(ADDR_SW'(w_eff));
    else              off = '0;
    off  = off + ADDR_SW'(dxc);
    asum = $signed(ADDR_SW'(out_slot_r)) + off;
    if (asum < 0)                                 asum = asum + ADDR_SW'(RING_LEN);
    else if (asum >= $signed(ADDR_SW'(RING_LEN))) asum = asum - ADDR_SW'(RING_LEN);
    raddr = asum[SLOT_W-1:0];
  end

  logic [PIX_W-1:0] rdata;
  agbs_ram #(.WIDTH(PIX_W), .DEPTH(RING_LEN)) u_line (
    .clk   (clk),
    .we    (accept && !in_chan.op),
    .waddr (in_slot_r),
    .wdata ({in_chan.in_alpha, in_chan.in_blue, in_chan.in_green, in_chan.in_red}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // border distance and thickness
  logic [DIM_W-1:0]   xr, yr, dmin;
  logic [THICK_W-1:0] t_eff, edge_m;
  always_comb begin
    t_eff = (thick_r == '0) ? THICK_W'(1) : thick_r;
    xr    = w_eff - 1'b1 - DIM_W'(out_col_r);
    yr    = h_eff - 1'b1 - DIM_W'(out_row_r);
    dmin  = DIM_W'(out_col_r);
    if (DIM_W'(out_row_r) < dmin) dmin = DIM_W'(out_row_r);
    if (xr < dmin)                dmin = xr;
    if (yr < dmin)                dmin = yr;
    edge_m = (dmin > DIM_W'(t_eff)) ? t_eff : dmin[THICK_W-1:0];
  end

  logic signed [DOT_W-1:0] dot;
  logic [CH_W-1:0]         lc [3];
  logic [N_W-1:0]          nprod [3];
  logic [NH_W-1:0]         dsh;
  logic [NH_W-1:0]         den8;
  assign dot  = p1_r + p2_r;
  assign dsh  = NH_W'(den_r) << cmd.div_bit;
  assign den8 = NH_W'(den_r) << Q_W;
  assign lc[0] = rgb_r[23:16];
  assign lc[1] = rgb_r[15:8];
  assign lc[2] = rgb_r[7:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nprod[c] = N_W'(dg_r) * N_W'(pos_r ? lc[c] : SHADOW_WEIGHT);
    end
  end

  // channel results
  logic [CH_W-1:0] chan_in [3];
  logic [CH_W-1:0] chan_out [3];
  logic [CH_W:0]   up, dn;
  assign chan_in[0] = pix_r[7:0];
  assign chan_in[1] = pix_r[15:8];
  assign chan_in[2] = pix_r[23:16];
  always_comb begin
    up = '0;
    dn = '0;
    for (int c = 0; c < 3; c++) begin
      up = {1'b0, chan_in[c]} + {1'b0, q_r[c]};
      dn = {1'b0, q_r[c]} + (CH_W+1)'((rem_r[c] != '0) || nz_r[c]);
      if (pix_r[31:24] < ALPHA_MIN) begin
        chan_out[c] = chan_in[c];
      end else if (pos_r) begin
        chan_out[c] = (big_r[c] || up > (CH_W+1)'(CH_MAX)) ? CH_MAX : up[CH_W-1:0];
      end else begin
        chan_out[c] = (big_r[c] || dn > (CH_W+1)'(chan_in[c])) ? '0
                      : chan_in[c] - dn[CH_W-1:0];
      end
    end
  end

  logic out_last;
  assign out_last = x_last && y_last;

  // control state: config, counters, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_W'(640);
      height_r    <= DIM_W'(480);
      thick_r     <= THICK_W'(5);
      cos_r       <= TRIG_W'(8192);
      sin_r       <= -TRIG_W'(14189);
      gain_r      <= GAIN_W'(256);
      rgb_r       <= '1;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_lin_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_lin_r   <= '0;
      out_slot_r  <= '0;
      frame_rcv_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      if (cmd.load) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          REG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
          REG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
          REG_THICK:  thick_r  <= cfg_wdata[THICK_W-1:0];
          REG_COS:    cos_r    <= cfg_wdata[TRIG_W-1:0];
          REG_SIN:    sin_r    <= cfg_wdata[TRIG_W-1:0];
          REG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
          REG_RGB:    rgb_r    <= cfg_wdata[RGB_W-1:0];
          default:    ;
        endcase
        if (cfg_idx_t'(cfg_addr) == REG_WIDTH || cfg_idx_t'(cfg_addr) == REG_HEIGHT) begin
          in_col_r    <= '0;
          in_row_r    <= '0;
          in_lin_r    <= '0;
          in_slot_r   <= '0;
          out_col_r   <= '0;
          out_row_r   <= '0;
          out_lin_r   <= '0;
          out_slot_r  <= '0;
          frame_rcv_r <= 1'b0;
        end
      end else if (accept && in_chan.op) begin
        if (frame_rcv_r && out_lin_r >= total_r) begin
          in_col_r    <= '0;
          in_row_r    <= '0;
          in_lin_r    <= '0;
          in_slot_r   <= '0;
          out_col_r   <= '0;
          out_row_r   <= '0;
          out_lin_r   <= '0;
          out_slot_r  <= '0;
          frame_rcv_r <= 1'b0;
        end
      end else if (accept) begin
        if (frame_rcv_r) begin
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_lin_r  <= '0;
          out_slot_r <= '0;
        end
        frame_rcv_r <= frame_wrap;
        if (frame_wrap) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          in_lin_r  <= '0;
          in_slot_r <= '0;
        end else begin
          in_lin_r  <= in_lin_r + 1'b1;
          in_slot_r <= in_slot_inc;
          if (col_wrap) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 1'b1;
          end else begin
            in_col_r <= in_col_r + 1'b1;
          end
        end
      end else if (cmd.load) begin
        if (out_last) begin
          in_col_r    <= '0;
          in_row_r    <= '0;
          in_lin_r    <= '0;
          in_slot_r   <= '0;
          out_col_r   <= '0;
          out_row_r   <= '0;
          out_lin_r   <= '0;
          out_slot_r  <= '0;
          frame_rcv_r <= 1'b0;
        end else begin
          out_lin_r  <= out_lin_r + 1'b1;
          out_slot_r <= out_slot_inc;
          if (x_last) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    total_r <= LIN_W'(w_eff) * LIN_W'(h_eff);
    if (accept) begin
      gx_r <= '0;
      gy_r <= '0;
    end
    if (cmd.acc_en) begin
      if (cmd.acc_idx == '0) begin
        pix_r <= rdata;
      end else begin
        if (nbr_dx(cmd.acc_idx) > 0)      gx_r <= gx_r + GRAD_W'(rdata[31:24]);
        else if (nbr_dx(cmd.acc_idx) < 0) gx_r <= gx_r - GRAD_W'(rdata[31:24]);
        if (nbr_dy(cmd.acc_idx) > 0)      gy_r <= gy_r + GRAD_W'(rdata[31:24]);
        else if (nbr_dy(cmd.acc_idx) < 0) gy_r <= gy_r - GRAD_W'(rdata[31:24]);
      end
    end
    if (cmd.mul1) begin
      p1_r  <= DOT_W'(gx_r) * DOT_W'(cos_r);
      p2_r  <= DOT_W'(gy_r) * DOT_W'(sin_r);
      gm_r  <= GM_W'(gain_r) * GM_W'(edge_m);
      den_r <= (DEN_W'(t_eff) << 8) - DEN_W'(t_eff);
    end
    if (cmd.mul2) begin
      pos_r <= (dot > 0);
      abs_r <= (dot > 0) ? ABS_W'(dot) : ABS_W'(-dot);
    end
    if (cmd.mul3) begin
      dg_r <= DG_W'(abs_r) * DG_W'(gm_r);
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd.mul4) begin
        nh_r[c] <= nprod[c][N_W-1:FRAC_SH];
        nz_r[c] <= (nprod[c][FRAC_SH-1:0] != '0);
      end
      if (cmd.div_init) begin
        big_r[c] <= (nh_r[c] >= den8);
        rem_r[c] <= nh_r[c];
        q_r[c]   <= '0;
      end
      if (cmd.div_step && !big_r[c] && rem_r[c] >= dsh) begin
        rem_r[c]              <= rem_r[c] - dsh;
        q_r[c][cmd.div_bit]   <= 1'b1;
      end
    end
    if (cmd.load) begin
      or_r <= chan_out[0];
      og_r <= chan_out[1];
      ob_r <= chan_out[2];
      oa_r <= pix_r[31:24];
      fe_r <= out_last;
    end
  end

  assign out_chan.valid     = ov_r;
  assign out_chan.out_red   = or_r;
  assign out_chan.out_green = og_r;
  assign out_chan.out_blue  = ob_r;
  assign out_chan.out_alpha = oa_r;
  assign out_chan.frame_end = fe_r;
endmodule

>>> rtl/alpha_gradient_bevel_shader.sv
// Top level of the alpha gradient bevel shader: controller plus datapath.
//
//   channel   direction  handshake           payload
//   in_chan   input      valid/ready         op, in_red, in_green, in_blue, in_alpha
//   out_chan  output     valid/ready         out_red, out_green, out_blue, out_alpha,
//                                            frame_end
//   cfg_*     input      cfg_we, no ready    cfg_addr (register index), cfg_wdata
//
// A beat that emits nothing needs no reads or arithmetic; a beat that emits a pixel runs
// nine reads of the single-read-port line store, four multiply stages and
// an eight-step quotient loop. One beat is in work at a time; the result register
// lets the next beat enter while a result waits. Reset is synchronous; the line
// store is not cleared, so no clearing pass is needed.
module alpha_gradient_bevel_shader (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [agbs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [agbs_pkg::CFG_W-1:0]  cfg_wdata,
  agbs_pix_in_if.sink                 in_chan,
  agbs_pix_out_if.source              out_chan
);
  import agbs_pkg::*;

  agbs_cmd_t cmd;
  agbs_sts_t sts;

  agbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  agbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule
